>>> hw/rtl/tbp_pkg.sv
// Shared types and constants for the tournament branch predictor.
package tbp_pkg;

   localparam int LOCAL_INDEX_BITS = 10;
   localparam int LOCAL_HIST_BITS = 10;
   localparam int GLOBAL_HIST_BITS = 12;
   localparam int LCTR_BITS = 3;
   localparam int GCTR_BITS = 2;

   localparam int CLEAR_BITS_A =
      (LOCAL_INDEX_BITS > LOCAL_HIST_BITS) ? LOCAL_INDEX_BITS : LOCAL_HIST_BITS;
   localparam int CLEAR_BITS =
      (CLEAR_BITS_A > GLOBAL_HIST_BITS) ? CLEAR_BITS_A : GLOBAL_HIST_BITS;

   typedef logic [LOCAL_INDEX_BITS-1:0] lidx_type;
   typedef logic [LOCAL_HIST_BITS-1:0] lhist_type;
   typedef logic [GLOBAL_HIST_BITS-1:0] ghist_type;
   typedef logic [LCTR_BITS-1:0] lctr_type;
   typedef logic [GCTR_BITS-1:0] gctr_type;
   typedef logic [CLEAR_BITS-1:0] clr_addr_type;

   localparam lctr_type LCTR_MAX = lctr_type'(7);
   localparam lctr_type LCTR_TAKEN = lctr_type'(4);
   localparam gctr_type GCTR_MAX = gctr_type'(3);
   localparam gctr_type GCTR_TAKEN = gctr_type'(2);

   typedef struct packed {
      logic [31:0] branch_address;
      logic        cond_branch;
      logic        is_call_or_return;
      logic        outcome_taken;
   } req_type;

   typedef struct packed {
      logic predicted_taken;
      logic used_global;
   } rsp_type;

   typedef struct packed {
      lctr_type lc;
      gctr_type gc;
      gctr_type cc;
   } ctr_type;

   typedef struct packed {
      logic     predicted_taken;
      logic     used_global;
      lctr_type lc_new;
      gctr_type gc_new;
      gctr_type cc_new;
   } upd_type;

   typedef struct packed {
      logic         busy;
      clr_addr_type addr;
   } clr_type;

endpackage

>>> hw/rtl/tournament_branch_predictor.sv
// Top level: three-stage table pipeline of the tournament branch predictor.
// Valid path: s1_valid_ff, s2_valid_ff, rsp_valid_ff. Throughput: one item per cycle
// unless rsp_ready or a clear stalls; the local history read feeding the local counter
// read sets the stage count, and same-entry overlaps are forwarded between stages.
// Reset: synchronous; then a clearing pass over 4096 addresses zeroes the tables,
// one entry per cycle, with req_ready held low until it completes.
module tournament_branch_predictor (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tbp_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tbp_pkg::rsp_type  rsp_payload
);
   import tbp_pkg::*;

   clr_type clr;
   logic    adv;
   logic    accept;
   lidx_type li0;

   ghist_type path_hist_ff;
   ghist_type path_hist_in;

   // Stage 1: local history read returned.
   logic      s1_valid_ff;
   lidx_type  s1_li_ff;
   ghist_type s1_gi_ff;
   logic      s1_cond_ff;
   logic      s1_callret_ff;
   logic      s1_taken_ff;
   logic      s1_lh_hit_ff;
   lhist_type s1_lh_fwd_ff;
   logic      s1_lh_hit_in;
   lhist_type lht_rd;
   lhist_type s1_lh;
   lhist_type s1_lh_new;

   // Stage 2: counter reads returned.
   logic      s2_valid_ff;
   lhist_type s2_lh_ff;
   ghist_type s2_gi_ff;
   logic      s2_cond_ff;
   logic      s2_callret_ff;
   logic      s2_taken_ff;
   logic      s2_lc_hit_ff;
   logic      s2_g_hit_ff;
   lctr_type  s2_lc_fwd_ff;
   gctr_type  s2_gc_fwd_ff;
   gctr_type  s2_cc_fwd_ff;
   logic      s2_lc_hit_in;
   logic      s2_g_hit_in;
   lctr_type  lct_rd;
   gctr_type  gct_rd;
   gctr_type  cct_rd;
   ctr_type   s2_ctr;
   upd_type   upd;
   logic      s2_write;

   logic      rsp_valid_ff;
   rsp_type   rsp_payload_ff;

   logic      lht_wr_en;
   lidx_type  lht_wr_addr;
   lhist_type lht_wr_data;
   logic      ctr_wr_en;
   lhist_type lct_wr_addr;
   ghist_type gct_wr_addr;
   lctr_type  lct_wr_data;
   gctr_type  gct_wr_data;
   gctr_type  cct_wr_data;

   tbp_clear u_clear (
      .clock (clock),
      .reset (reset),
      .clr   (clr)
   );

   assign adv = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv && !clr.busy;
   assign accept = req_valid && req_ready;
   assign li0 = req_payload.branch_address[LOCAL_INDEX_BITS+1:2];

   assign path_hist_in = {path_hist_ff[GLOBAL_HIST_BITS-2:0], req_payload.outcome_taken};

   assign s1_lh = s1_lh_hit_ff ? s1_lh_fwd_ff : lht_rd;
   assign s1_lh_new = {s1_lh[LOCAL_HIST_BITS-2:0], s1_taken_ff};
   assign s1_lh_hit_in = s1_valid_ff && (s1_li_ff == li0);

   assign s2_ctr.lc = s2_lc_hit_ff ? s2_lc_fwd_ff : lct_rd;
   assign s2_ctr.gc = s2_g_hit_ff ? s2_gc_fwd_ff : gct_rd;
   assign s2_ctr.cc = s2_g_hit_ff ? s2_cc_fwd_ff : cct_rd;
   assign s2_write = s2_valid_ff && s2_cond_ff;
   assign s2_lc_hit_in = s2_write && (s2_lh_ff == s1_lh);
   assign s2_g_hit_in = s2_write && (s2_gi_ff == s1_gi_ff);

   tbp_update u_update (
      .ctr               (s2_ctr),
      .cond_branch       (s2_cond_ff),
      .is_call_or_return (s2_callret_ff),
      .outcome_taken     (s2_taken_ff),
      .upd               (upd)
   );

   always_comb begin
      if (clr.busy) begin
         lht_wr_en = 1'b1;
         lht_wr_addr = clr.addr[LOCAL_INDEX_BITS-1:0];
         lht_wr_data = '0;
         ctr_wr_en = 1'b1;
         lct_wr_addr = clr.addr[LOCAL_HIST_BITS-1:0];
         gct_wr_addr = clr.addr[GLOBAL_HIST_BITS-1:0];
         lct_wr_data = '0;
         gct_wr_data = '0;
         cct_wr_data = '0;
      end else begin
         lht_wr_en = adv && s1_valid_ff;
         lht_wr_addr = s1_li_ff;
         lht_wr_data = s1_lh_new;
         ctr_wr_en = adv && s2_write;
         lct_wr_addr = s2_lh_ff;
         gct_wr_addr = s2_gi_ff;
         lct_wr_data = upd.lc_new;
         gct_wr_data = upd.gc_new;
         cct_wr_data = upd.cc_new;
      end
   end

   tbp_ram #(.WIDTH(LOCAL_HIST_BITS), .ADDR_BITS(LOCAL_INDEX_BITS)) u_lht (
      .clock   (clock),
      .rd_en   (adv),
      .rd_addr (li0),
      .rd_data (lht_rd),
      .wr_en   (lht_wr_en),
      .wr_addr (lht_wr_addr),
      .wr_data (lht_wr_data)
   );

   tbp_ram #(.WIDTH(LCTR_BITS), .ADDR_BITS(LOCAL_HIST_BITS)) u_lct (
      .clock   (clock),
      .rd_en   (adv),
      .rd_addr (s1_lh),
      .rd_data (lct_rd),
      .wr_en   (ctr_wr_en),
      .wr_addr (lct_wr_addr),
      .wr_data (lct_wr_data)
   );

   tbp_ram #(.WIDTH(GCTR_BITS), .ADDR_BITS(GLOBAL_HIST_BITS)) u_gct (
      .clock   (clock),
      .rd_en   (adv),
      .rd_addr (s1_gi_ff),
      .rd_data (gct_rd),
      .wr_en   (ctr_wr_en),
      .wr_addr (gct_wr_addr),
      .wr_data (gct_wr_data)
   );

   tbp_ram #(.WIDTH(GCTR_BITS), .ADDR_BITS(GLOBAL_HIST_BITS)) u_cct (
      .clock   (clock),
      .rd_en   (adv),
      .rd_addr (s1_gi_ff),
      .rd_data (cct_rd),
      .wr_en   (ctr_wr_en),
      .wr_addr (gct_wr_addr),
      .wr_data (cct_wr_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         path_hist_ff <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            path_hist_ff <= path_hist_in;
         end
         if (adv) begin
            s1_valid_ff <= accept;
            s2_valid_ff <= s1_valid_ff;
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_li_ff <= li0;
         s1_gi_ff <= path_hist_ff;
         s1_cond_ff <= req_payload.cond_branch;
         s1_callret_ff <= req_payload.is_call_or_return;
         s1_taken_ff <= req_payload.outcome_taken;
         s1_lh_hit_ff <= s1_lh_hit_in;
         s1_lh_fwd_ff <= s1_lh_new;

         s2_lh_ff <= s1_lh;
         s2_gi_ff <= s1_gi_ff;
         s2_cond_ff <= s1_cond_ff;
         s2_callret_ff <= s1_callret_ff;
         s2_taken_ff <= s1_taken_ff;
         s2_lc_hit_ff <= s2_lc_hit_in;
         s2_g_hit_ff <= s2_g_hit_in;
         s2_lc_fwd_ff <= upd.lc_new;
         s2_gc_fwd_ff <= upd.gc_new;
         s2_cc_fwd_ff <= upd.cc_new;

         rsp_payload_ff.predicted_taken <= upd.predicted_taken;
         rsp_payload_ff.used_global <= upd.used_global;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

>>> hw/rtl/tbp_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
module tbp_ram #(
   parameter int WIDTH = 2,
   parameter int ADDR_BITS = 4
) (
   input  logic                 clock,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data
);

   logic [WIDTH-1:0] mem [2**ADDR_BITS];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/tbp_clear.sv
// Clearing sequencer that zeroes every table entry after reset.
module tbp_clear (
   input  logic              clock,
   input  logic              reset,
   output tbp_pkg::clr_type  clr
);
   import tbp_pkg::*;

   logic         busy_ff;
   logic         busy_in;
   clr_addr_type addr_ff;
   clr_addr_type addr_in;

   always_comb begin
      busy_in = busy_ff;
      addr_in = addr_ff;
      if (busy_ff) begin
         addr_in = addr_ff + clr_addr_type'(1);
         if (addr_ff == {CLEAR_BITS{1'b1}}) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         addr_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         addr_ff <= addr_in;
      end
   end

   assign clr.busy = busy_ff;
   assign clr.addr = addr_ff;

endmodule

>>> hw/rtl/tbp_update.sv
// Prediction select and saturating counter update for one branch.
module tbp_update (
   input  tbp_pkg::ctr_type ctr,
   input  logic             cond_branch,
   input  logic             is_call_or_return,
   input  logic             outcome_taken,
   output tbp_pkg::upd_type upd
);
   import tbp_pkg::*;

   logic local_dir;
   logic global_dir;
   logic sel_global;

   always_comb begin
      local_dir = ctr.lc >= LCTR_TAKEN;
      global_dir = ctr.gc >= GCTR_TAKEN;
      sel_global = ctr.cc >= GCTR_TAKEN;

      if (is_call_or_return || !cond_branch) begin
         upd.predicted_taken = 1'b1;
         upd.used_global = 1'b0;
      end else begin
         upd.predicted_taken = sel_global ? global_dir : local_dir;
         upd.used_global = sel_global;
      end

      if (outcome_taken) begin
         upd.lc_new = (ctr.lc == LCTR_MAX) ? ctr.lc : ctr.lc + lctr_type'(1);
         upd.gc_new = (ctr.gc == GCTR_MAX) ? ctr.gc : ctr.gc + gctr_type'(1);
      end else begin
         upd.lc_new = (ctr.lc == '0) ? ctr.lc : ctr.lc - lctr_type'(1);
         upd.gc_new = (ctr.gc == '0) ? ctr.gc : ctr.gc - gctr_type'(1);
      end

      upd.cc_new = ctr.cc;
      if (local_dir != global_dir) begin
         if (global_dir == outcome_taken) begin
            upd.cc_new = (ctr.cc == GCTR_MAX) ? ctr.cc : ctr.cc + gctr_type'(1);
         end else begin
            upd.cc_new = (ctr.cc == '0) ? ctr.cc : ctr.cc - gctr_type'(1);
         end
      end
   end

endmodule
